// File: hw/rtl/htw_pkg.sv
// Package for the hierarchical timer wheel: command and result codes, widths, defaults.
// Used by the top level, the command queue and the engine; depends on nothing.
package htw_pkg;

    localparam int DEF_NUM_SLOTS  = 32;
    localparam int DEF_LEVEL_BITS = 8;
    localparam int DEF_NUM_LEVELS = 4;

    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 5;
    localparam int DELAY_W = 32;
    localparam int SEQ_W   = 16;
    localparam int CNT_W   = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_SCHEDULE   = 2'd0,
        CMD_CANCEL     = 2'd1,
        CMD_TICK       = 2'd2,
        CMD_CANCEL_ALL = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_ACK     = 2'd0,
        KIND_EXPIRED = 2'd1,
        KIND_CANCEL  = 2'd2,
        KIND_DONE    = 2'd3
    } t_kind;

    // One queued command between the front and the back part.
    typedef struct packed {
        t_cmd               cmd;
        logic [SLOT_W-1:0]  slot;
        logic [DELAY_W-1:0] delay;
    } t_cmd_item;

    // One result item.
    typedef struct packed {
        t_kind              kind;
        logic [SLOT_W-1:0]  slot;
        logic [SEQ_W-1:0]   seq;
        logic               was_cancelled;
        logic [CNT_W-1:0]   active_count;
        logic               last;
    } t_result;

endpackage

// File: hw/rtl/hierarchical_timer_wheel_unit.sv
// Top level of the hierarchical timer wheel: intake queue plus wheel engine.
// Depends on htw_pkg, htw_cmd_fifo and htw_engine.
//
// Usage: commands arrive on the s_axis channel (tdata holds cmd, slot,
// delay_ticks from the lowest bit up). Results leave on m_axis, one transfer
// per result; tlast marks the final result of a command.
// Flow: with an idle engine, a schedule or cancel passes through the queue,
// the engine's command register and the result register. A tick walks the
// slot table once per cascaded level (at least one level), then once more to
// emit; cancel-all walks it once to emit. The engine walks the slot table one
// slot a cycle, and while emitting only when the output is not stalled. A
// two-entry queue takes commands meanwhile.
// Reset clears every slot, the tick counter and the armed total at once.
// When the receiver stalls, the engine holds its result register and waits;
// the queue then fills and s_axis_tready falls.
module hierarchical_timer_wheel_unit #(
    parameter int NUM_SLOTS  = htw_pkg::DEF_NUM_SLOTS,
    parameter int LEVEL_BITS = htw_pkg::DEF_LEVEL_BITS,
    parameter int NUM_LEVELS = htw_pkg::DEF_NUM_LEVELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // cmd[1:0], slot[6:2], delay_ticks[38:7], pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // kind[1:0], timer_slot[6:2], sequence_id[22:7],
                                       // was_cancelled[23], active_count[29:24], pad
    output logic        m_axis_tlast
);
    import htw_pkg::*;

    t_cmd_item w_in, w_q;
    logic      w_q_valid, w_q_ready;
    t_result   w_res;

    assign w_in.cmd   = t_cmd'(s_axis_tdata[1:0]);
    assign w_in.slot  = s_axis_tdata[6:2];
    assign w_in.delay = s_axis_tdata[38:7];

    htw_cmd_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_wr_valid(s_axis_tvalid), .o_wr_ready(s_axis_tready), .i_wr_item(w_in),
        .o_rd_valid(w_q_valid), .i_rd_ready(w_q_ready), .o_rd_item(w_q)
    );

    htw_engine #(
        .NUM_SLOTS(NUM_SLOTS), .LEVEL_BITS(LEVEL_BITS), .NUM_LEVELS(NUM_LEVELS)
    ) u_eng (
        .i_clk, .i_rst_n,
        .i_cmd_valid(w_q_valid), .o_cmd_ready(w_q_ready), .i_cmd_item(w_q),
        .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready), .o_res(w_res)
    );

    // Result packing.
    assign m_axis_tdata = {2'b00, w_res.active_count, w_res.was_cancelled, w_res.seq,
                           w_res.slot, w_res.kind};
    assign m_axis_tlast = w_res.last;
endmodule

// File: hw/rtl/htw_cmd_fifo.sv
// Command queue between the intake side and the wheel engine.
// Depends on htw_pkg for the command item type.
module htw_cmd_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_valid,
    output logic               o_wr_ready,
    input  htw_pkg::t_cmd_item i_wr_item,
    output logic               o_rd_valid,
    input  logic               i_rd_ready,
    output htw_pkg::t_cmd_item o_rd_item
);
    import htw_pkg::*;

    t_cmd_item   r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        w_wr, w_rd;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_rd_item  = r_mem[r_rp];
    assign w_wr = i_wr_valid && o_wr_ready;
    assign w_rd = o_rd_valid && i_rd_ready;

    // Two-entry queue storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_wr_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end
endmodule

// File: hw/rtl/htw_engine.sv
// Wheel engine: slot table, tick counter, and the sequencer that carries out commands.
// Depends on htw_pkg; fed by htw_cmd_fifo, drives a one-entry output register.
module htw_engine #(
    parameter int NUM_SLOTS  = htw_pkg::DEF_NUM_SLOTS,
    parameter int LEVEL_BITS = htw_pkg::DEF_LEVEL_BITS,
    parameter int NUM_LEVELS = htw_pkg::DEF_NUM_LEVELS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  htw_pkg::t_cmd_item i_cmd_item,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output htw_pkg::t_result   o_res
);
    import htw_pkg::*;

    localparam int IDX_W  = $clog2(NUM_SLOTS);
    localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int SPAN   = LEVEL_BITS * NUM_LEVELS;
    localparam logic [DELAY_W-1:0] MAX_DELAY =
        (SPAN < DELAY_W) ? DELAY_W'((64'd1 << SPAN) - 64'd1) : {DELAY_W{1'b1}};

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PLACE = 6'b000010,
        ST_MARK  = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_EMIT  = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    // Slot table.
    logic                  r_armed  [NUM_SLOTS];
    logic [LVL_W-1:0]      r_level  [NUM_SLOTS];
    logic [LEVEL_BITS-1:0] r_bucket [NUM_SLOTS];
    logic [DELAY_W-1:0]    r_expiry [NUM_SLOTS];
    logic [SEQ_W-1:0]      r_seq    [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  r_fire;

    logic [DELAY_W-1:0] r_now;
    logic [CNT_W-1:0]   r_total;
    t_state             r_state;
    t_cmd_item          r_cmd;
    logic [IDX_W-1:0]   r_idx;
    logic [LVL_W-1:0]   r_lvl;
    logic               r_ovalid;
    t_result            r_out;

    logic w_slot_ok, w_out_free, w_load;
    logic [IDX_W-1:0] w_s;
    logic [DELAY_W-1:0] w_delay;
    assign w_slot_ok = ({1'b0, r_cmd.slot} < (SLOT_W+1)'(NUM_SLOTS));
    assign w_s       = IDX_W'(r_cmd.slot);
    assign w_out_free = !r_ovalid || i_res_ready;
    assign o_res_valid = r_ovalid;
    assign o_res       = r_out;
    assign o_cmd_ready = (r_state == ST_IDLE);

    // Clamped delay for schedule.
    always_comb begin
        w_delay = (i_cmd_item.delay == '0) ? DELAY_W'(1) : i_cmd_item.delay;
        if (w_delay > MAX_DELAY) w_delay = MAX_DELAY;
    end

    // Placement of a slot from its expiry relative to the current tick.
    function automatic logic [LVL_W+LEVEL_BITS-1:0] place_f(
        input logic [DELAY_W-1:0] exp, input logic [DELAY_W-1:0] now);
        logic [DELAY_W-1:0] diff;
        logic [DELAY_W-1:0] t;
        logic [LVL_W-1:0]   lv;
        diff = exp - now;
        t    = exp;
        lv   = '0;
        for (int k = 0; k < NUM_LEVELS - 1; k++) begin
            if ((diff >> LEVEL_BITS) != '0) begin
                diff = diff >> LEVEL_BITS;
                t    = t >> LEVEL_BITS;
                lv   = lv + 1'b1;
            end
        end
        return {lv, t[LEVEL_BITS-1:0]};
    endfunction

    // Bucket of the current tick at the level being cascaded, and the new placement of the slot under scan.
    logic [DELAY_W-1:0]    w_shift;
    logic [LEVEL_BITS-1:0] w_bk;
    logic [IDX_W-1:0]      w_i;
    logic [LVL_W+LEVEL_BITS-1:0] w_pl;
    always_comb begin
        w_shift = r_now >> (LEVEL_BITS * int'(r_lvl));
        w_bk    = w_shift[LEVEL_BITS-1:0];
        w_i     = r_idx;
        w_pl    = place_f(r_expiry[w_i], r_now);
    end

    // A result enters the output register in this cycle.
    always_comb begin
        w_load = 1'b0;
        if (w_out_free) begin
            unique case (r_state)
                ST_PLACE, ST_DONE: w_load = 1'b1;
                ST_EMIT: w_load = (r_cmd.cmd == CMD_TICK) ? r_fire[w_i] : r_armed[w_i];
                default: w_load = 1'b0;
            endcase
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (i_res_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Command sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_now    <= '0;
            r_total  <= '0;
            r_fire   <= '0;
            r_idx    <= '0;
            r_lvl    <= '0;
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_armed[k]  <= 1'b0;
                r_level[k]  <= '0;
                r_bucket[k] <= '0;
                r_expiry[k] <= '0;
                r_seq[k]    <= '0;
            end
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd  <= '{cmd: i_cmd_item.cmd, slot: i_cmd_item.slot,
                                    delay: w_delay};
                        r_idx  <= '0;
                        r_fire <= '0;
                        if (i_cmd_item.cmd == CMD_TICK) begin
                            r_now   <= r_now + 1'b1;
                            r_lvl   <= '0;
                            r_state <= ST_MARK;
                        end else if (i_cmd_item.cmd == CMD_CANCEL_ALL) begin
                            r_state <= ST_EMIT;
                        end else begin
                            r_state <= ST_PLACE;
                        end
                    end
                end
                // Schedule or cancel: at most one table update and one result.
                ST_PLACE: begin
                    if (w_out_free) begin
                        r_out.last <= 1'b1;
                        r_state <= ST_IDLE;
                        if (!w_slot_ok) begin
                            r_out.kind <= (r_cmd.cmd == CMD_SCHEDULE) ? KIND_DONE : KIND_CANCEL;
                            r_out.slot <= (r_cmd.cmd == CMD_SCHEDULE) ? '0 : r_cmd.slot;
                            r_out.seq  <= '0;
                            r_out.was_cancelled <= 1'b0;
                            r_out.active_count <= r_total;
                        end else if (r_cmd.cmd == CMD_SCHEDULE) begin
                            r_expiry[w_s] <= r_now + r_cmd.delay;
                            {r_level[w_s], r_bucket[w_s]} <=
                                place_f(r_now + r_cmd.delay, r_now);
                            r_armed[w_s] <= 1'b1;
                            r_seq[w_s]   <= r_seq[w_s] + 1'b1;
                            r_total <= r_armed[w_s] ? r_total : r_total + 1'b1;
                            r_out.kind <= KIND_ACK;
                            r_out.slot <= r_cmd.slot;
                            r_out.seq  <= r_seq[w_s] + 1'b1;
                            r_out.was_cancelled <= 1'b0;
                            r_out.active_count <= r_armed[w_s] ? r_total : r_total + 1'b1;
                        end else begin
                            r_armed[w_s]  <= 1'b0;
                            r_level[w_s]  <= '0;
                            r_bucket[w_s] <= '0;
                            r_total <= r_armed[w_s] ? r_total - 1'b1 : r_total;
                            r_out.kind <= KIND_CANCEL;
                            r_out.slot <= r_cmd.slot;
                            r_out.seq  <= r_seq[w_s];
                            r_out.was_cancelled <= r_armed[w_s];
                            r_out.active_count <= r_armed[w_s] ? r_total - 1'b1 : r_total;
                        end
                    end
                end
                // Level 0 marks, then cascading levels, one slot per cycle.
                ST_MARK: begin
                    if (r_armed[w_i] && !r_fire[w_i] && r_level[w_i] == r_lvl &&
                        r_bucket[w_i] == w_bk) begin
                        if (r_lvl == '0 || r_expiry[w_i] == r_now) begin
                            r_fire[w_i] <= 1'b1;
                        end else begin
                            {r_level[w_i], r_bucket[w_i]} <= w_pl;
                        end
                    end
                    if (r_idx == IDX_W'(NUM_SLOTS - 1)) begin
                        r_idx <= '0;
                        if ((r_lvl == '0 ? w_bk == '0 : w_bk == '0) &&
                            int'(r_lvl) < NUM_LEVELS - 1 &&
                            (r_lvl == '0 || w_bk == '0)) begin
                            r_lvl <= r_lvl + 1'b1;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                // Count the survivors so every result carries the final total.
                ST_SCAN: begin
                    for (int k = 0; k < NUM_SLOTS; k++) begin
                        if (r_fire[k]) r_armed[k] <= 1'b0;
                    end
                    r_total <= r_total - CNT_W'($countones(r_fire));
                    r_state <= ST_EMIT;
                end
                // Emit one notice per fired (tick) or armed (cancel all) slot.
                ST_EMIT: begin
                    if (w_out_free) begin
                        if (r_cmd.cmd == CMD_TICK) begin
                            if (r_fire[w_i]) begin
                                r_level[w_i]  <= '0;
                                r_bucket[w_i] <= '0;
                                r_out <= '{KIND_EXPIRED, SLOT_W'(w_i), r_seq[w_i], 1'b0,
                                           r_total, 1'b0};
                            end
                        end else begin
                            r_level[w_i]  <= '0;
                            r_bucket[w_i] <= '0;
                            r_armed[w_i]  <= 1'b0;
                            if (r_armed[w_i]) begin
                                r_out <= '{KIND_CANCEL, SLOT_W'(w_i), r_seq[w_i], 1'b1,
                                           '0, 1'b0};
                            end
                        end
                        if (r_idx == IDX_W'(NUM_SLOTS - 1)) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        if (r_cmd.cmd == CMD_CANCEL_ALL) r_total <= '0;
                        r_out <= '{KIND_DONE, '0, '0, 1'b0,
                                   (r_cmd.cmd == CMD_CANCEL_ALL) ? '0 : r_total, 1'b1};
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

// File: hw/rtl/htw_checker.sv
// Port-level checker for the timer wheel top level, attached by bind.
// Depends on nothing but the top level's ports.
module htw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // The armed count never exceeds 32.
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[29:24] <= 6'd32)
        else $error("active count out of range");

    // A done result carries zero slot and id.
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == 2'd3 |-> m_axis_tlast &&
        m_axis_tdata[22:2] == 21'd0)
        else $error("malformed done result");

    // Schedule acks are always final.
    a_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == 2'd0 |-> m_axis_tlast)
        else $error("ack not final");
endmodule

bind hierarchical_timer_wheel_unit htw_checker u_chk (
    .i_clk, .i_rst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);

// File: tb/sv/tb_top.sv
// Self-checking testbench for the hierarchical timer wheel unit.
// Depends on htw_pkg and hierarchical_timer_wheel_unit; a built-in wheel predictor checks every result.
module tb_top;
    import htw_pkg::*;

    localparam int NS    = DEF_NUM_SLOTS;
    localparam int LB    = DEF_LEVEL_BITS;
    localparam int NL    = DEF_NUM_LEVELS;
    localparam int BMASK = (1 << LB) - 1;

    typedef struct {
        t_cmd        cmd;
        logic [4:0]  slot;
        logic [31:0] delay;
    } t_command;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;  // cmd[1:0], slot[6:2], delay_ticks[38:7], pad
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;  // kind[1:0], timer_slot[6:2], sequence_id[22:7],
                                // was_cancelled[23], active_count[29:24], pad
    logic        m_axis_tlast;

    hierarchical_timer_wheel_unit dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    // Clock with a period of 4 time units.
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Wheel state mirrored by the predictor.
    logic        armed [NS];
    int          wheel_lvl [NS];
    logic [LB-1:0] wheel_bkt [NS];
    logic [31:0] expiry_at [NS];
    logic [15:0] slot_seq [NS];
    logic [31:0] cur_tick;
    int          live_timers;

    t_command pending_cmds[$];
    t_result  expected_results[$];
    t_command cur_cmd;
    int       errors;
    int       cmds_sent;
    int       results_seen;
    int       n_ticks;
    int       n_expiries;
    int       n_cancels;
    int       send_gap;
    int       recv_gap;
    int       hold_off;
    logic     hold_done;

    // Short gaps mostly, a long one now and then; none inside the quiet window.
    function automatic int pick_gap(int count);
        int r;
        r = $urandom_range(0, 99);
        if (count >= 150 && count < 230)
            return 0;
        if (r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Files a timer into the wheel level and bucket that its distance selects.
    task automatic wheel_place(int s);
        logic [31:0] remain;
        logic [31:0] t;
        int lev;
        remain = expiry_at[s] - cur_tick;
        t = expiry_at[s];
        lev = 0;
        while (remain > BMASK && lev < NL - 1) begin
            remain = remain >> LB;
            t = t >> LB;
            lev++;
        end
        wheel_lvl[s] = lev;
        wheel_bkt[s] = t[LB-1:0];
    endtask

    task automatic wheel_disarm(int s);
        if (armed[s]) begin
            armed[s] = 1'b0;
            if (live_timers > 0)
                live_timers--;
        end
        wheel_lvl[s] = 0;
        wheel_bkt[s] = '0;
    endtask

    function automatic t_result make_result(t_kind k, int s, logic [15:0] q, logic wc,
                                            logic lst);
        t_result r;
        r.kind = k;
        r.slot = s[4:0];
        r.seq = q;
        r.was_cancelled = wc;
        r.active_count = '0;
        r.last = lst;
        return r;
    endfunction

    // Applies one accepted command to the wheel and queues the results it causes.
    task automatic predict_wheel(t_command c);
        t_result outs[$];
        logic fire [NS];
        logic [31:0] d;
        logic [31:0] t;
        logic [LB-1:0] b;
        int s;
        s = c.slot;
        case (c.cmd)
            CMD_SCHEDULE: begin
                wheel_disarm(s);
                d = (c.delay == 0) ? 32'd1 : c.delay;
                if (LB * NL < 32 && d > (32'd1 << (LB * NL)) - 1)
                    d = (32'd1 << (LB * NL)) - 1;
                expiry_at[s] = cur_tick + d;
                wheel_place(s);
                armed[s] = 1'b1;
                live_timers++;
                slot_seq[s] = slot_seq[s] + 1;
                outs.push_back(make_result(KIND_ACK, s, slot_seq[s], 1'b0, 1'b1));
            end
            CMD_CANCEL: begin
                outs.push_back(make_result(KIND_CANCEL, s, slot_seq[s], armed[s], 1'b1));
                wheel_disarm(s);
            end
            CMD_TICK: begin
                n_ticks++;
                cur_tick = cur_tick + 1;
                for (int i = 0; i < NS; i++)
                    fire[i] = armed[i] && wheel_lvl[i] == 0 && wheel_bkt[i] == cur_tick[LB-1:0];
                // Wrap of level 0 cascades level 1, and each higher level while the bucket of the one below is zero.
                if (cur_tick[LB-1:0] == 0) begin
                    t = cur_tick >> LB;
                    for (int lev = 1; lev < NL; lev++) begin
                        b = t[LB-1:0];
                        for (int i = 0; i < NS; i++) begin
                            if (armed[i] && !fire[i] && wheel_lvl[i] == lev &&
                                wheel_bkt[i] == b) begin
                                if (expiry_at[i] == cur_tick)
                                    fire[i] = 1'b1;
                                else
                                    wheel_place(i);
                            end
                        end
                        if (b != 0)
                            break;
                        t = t >> LB;
                    end
                end
                for (int i = 0; i < NS; i++) begin
                    if (fire[i]) begin
                        wheel_disarm(i);
                        n_expiries++;
                        outs.push_back(make_result(KIND_EXPIRED, i, slot_seq[i], 1'b0, 1'b0));
                    end
                end
                outs.push_back(make_result(KIND_DONE, 0, '0, 1'b0, 1'b1));
            end
            default: begin
                for (int i = 0; i < NS; i++) begin
                    if (armed[i]) begin
                        n_cancels++;
                        outs.push_back(make_result(KIND_CANCEL, i, slot_seq[i], 1'b1, 1'b0));
                    end
                    wheel_disarm(i);
                end
                live_timers = 0;
                outs.push_back(make_result(KIND_DONE, 0, '0, 1'b0, 1'b1));
            end
        endcase
        foreach (outs[k]) begin
            outs[k].active_count = live_timers[5:0];
            expected_results.push_back(outs[k]);
        end
    endtask

    // Command driver: predicts each accepted transfer, then offers the next item.
    always @(posedge i_clk) begin
        logic nxt_valid;
        nxt_valid = s_axis_tvalid;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_wheel(cur_cmd);
                cmds_sent++;
                nxt_valid = 1'b0;
                send_gap = pick_gap(cmds_sent);
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_cmds.size() > 0) begin
                    cur_cmd = pending_cmds.pop_front();
                    s_axis_tdata <= {1'b0, cur_cmd.delay, cur_cmd.slot, cur_cmd.cmd};
                    nxt_valid = 1'b1;
                end
            end
        end
        s_axis_tvalid <= nxt_valid;
    end

    // One long receiver hold-off, counted here, while commands keep coming.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_off <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && results_seen >= 120) begin
            hold_off <= 400;
            hold_done <= 1'b1;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
        end
    end

    // Result monitor: compares every transfer and paces the ready line.
    always @(posedge i_clk) begin
        t_result want;
        logic nxt_ready;
        nxt_ready = 1'b0;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result transfer: tdata %h", m_axis_tdata);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tdata[1:0] !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, m_axis_tdata[1:0]);
                        errors++;
                    end
                    if (m_axis_tdata[6:2] !== want.slot) begin
                        $error("timer_slot: expected %0d, got %0d", want.slot,
                               m_axis_tdata[6:2]);
                        errors++;
                    end
                    if (m_axis_tdata[22:7] !== want.seq) begin
                        $error("sequence_id: expected %0d, got %0d", want.seq,
                               m_axis_tdata[22:7]);
                        errors++;
                    end
                    if (m_axis_tdata[23] !== want.was_cancelled) begin
                        $error("was_cancelled: expected %0d, got %0d", want.was_cancelled,
                               m_axis_tdata[23]);
                        errors++;
                    end
                    if (m_axis_tdata[29:24] !== want.active_count) begin
                        $error("active_count: expected %0d, got %0d", want.active_count,
                               m_axis_tdata[29:24]);
                        errors++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                        errors++;
                    end
                end
                recv_gap = pick_gap(results_seen);
            end
            if (hold_off == 0) begin
                if (recv_gap > 0)
                    recv_gap--;
                else
                    nxt_ready = 1'b1;
            end
        end
        m_axis_tready <= nxt_ready;
    end

    function automatic t_command mk(t_cmd c, int s, logic [31:0] d);
        t_command x;
        x.cmd = c;
        x.slot = s[4:0];
        x.delay = d;
        return x;
    endfunction

    // Stimulus, reset and end of run.
    initial begin
        int r;
        logic [31:0] d;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_rst_n = 1'b0;
        errors = 0;
        cmds_sent = 0;
        results_seen = 0;
        n_ticks = 0;
        n_expiries = 0;
        n_cancels = 0;
        send_gap = 0;
        recv_gap = 0;
        cur_cmd = mk(CMD_TICK, 0, '0);
        cur_tick = '0;
        live_timers = 0;
        for (int i = 0; i < NS; i++) begin
            armed[i] = 1'b0;
            wheel_lvl[i] = 0;
            wheel_bkt[i] = '0;
            expiry_at[i] = '0;
            slot_seq[i] = '0;
        end

        // Directed: zero delay, bucket edges, full-width delay, cancels and reschedules.
        pending_cmds.push_back(mk(CMD_CANCEL, 3, '0));
        pending_cmds.push_back(mk(CMD_SCHEDULE, 0, 32'd0));
        pending_cmds.push_back(mk(CMD_SCHEDULE, 31, 32'd1));
        pending_cmds.push_back(mk(CMD_SCHEDULE, 5, 32'd255));
        pending_cmds.push_back(mk(CMD_SCHEDULE, 6, 32'd256));
        pending_cmds.push_back(mk(CMD_SCHEDULE, 7, 32'h0001_0000));
        pending_cmds.push_back(mk(CMD_SCHEDULE, 8, 32'hFFFF_FFFF));
        pending_cmds.push_back(mk(CMD_SCHEDULE, 9, 32'd3));
        pending_cmds.push_back(mk(CMD_SCHEDULE, 9, 32'd2));
        pending_cmds.push_back(mk(CMD_TICK, 0, '0));
        pending_cmds.push_back(mk(CMD_TICK, 0, '0));
        pending_cmds.push_back(mk(CMD_CANCEL, 5, '0));
        pending_cmds.push_back(mk(CMD_CANCEL, 5, '0));
        pending_cmds.push_back(mk(CMD_TICK, 0, '0));
        pending_cmds.push_back(mk(CMD_CANCEL_ALL, 0, '0));
        pending_cmds.push_back(mk(CMD_CANCEL_ALL, 0, '0));
        for (int i = 0; i < 4; i++)
            pending_cmds.push_back(mk(CMD_SCHEDULE, 12 + i, 32'd4));
        pending_cmds.push_back(mk(CMD_TICK, 31, 32'hFFFF_FFFF));
        pending_cmds.push_back(mk(CMD_TICK, 0, '0));
        pending_cmds.push_back(mk(CMD_TICK, 0, '0));

        // Random: mostly ticks so timers expire and the wheel passes a level-1 cascade.
        for (int n = 0; n < 357; n++) begin
            r = $urandom_range(0, 99);
            if (r < 76) begin
                pending_cmds.push_back(mk(CMD_TICK, $urandom_range(0, 31), $urandom));
            end else if (r < 93) begin
                case ($urandom_range(0, 9))
                    0: d = $urandom;
                    1: d = $urandom_range(256, 70000);
                    2: d = 32'd0;
                    default: d = $urandom_range(1, 300);
                endcase
                pending_cmds.push_back(mk(CMD_SCHEDULE, $urandom_range(0, 31), d));
            end else if (r < 99) begin
                pending_cmds.push_back(mk(CMD_CANCEL, $urandom_range(0, 31), $urandom));
            end else begin
                pending_cmds.push_back(mk(CMD_CANCEL_ALL, $urandom_range(0, 31), $urandom));
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("Ran %0d commands with %0d ticks (wheel at tick %0d), %0d result transfers.",
                 cmds_sent, n_ticks, cur_tick, results_seen);
        $display("Covered %0d timer expiries and %0d cancel-all notices.", n_expiries,
                 n_cancels);
        if (errors == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #8000000;
        $display("Timeout waiting for the block to drain.");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/htw_pkg.sv
hw/rtl/htw_cmd_fifo.sv
hw/rtl/htw_engine.sv
hw/rtl/hierarchical_timer_wheel_unit.sv
hw/rtl/htw_checker.sv
tb/sv/tb_top.sv
